>>> rtl/ast_pkg.sv
package ast_pkg;

   // Fixed field widths of one result
   localparam int KIND_BITS = 4;
   localparam int CODE_BITS = 3;
   localparam int LEN_BITS  = 16;

   // One source byte can close a pending token, emit a punctuation or
   // newline token and end the source: at most three results per beat.
   localparam int MAX_RES  = 3;
   localparam int CNT_BITS = 2;

   // Bundle queue between tokenizer front and result back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_NEWLINE  = 4'd0,
      KIND_ASTERISK = 4'd1,
      KIND_COLON    = 4'd2,
      KIND_DOT      = 4'd3,
      KIND_COMMA    = 4'd4,
      KIND_LBRACKET = 4'd5,
      KIND_RBRACKET = 4'd6,
      KIND_STRING   = 4'd7,
      KIND_REGISTER = 4'd8,
      KIND_WORD     = 4'd9,
      KIND_IDENT    = 4'd10,
      KIND_EOF      = 4'd11,
      KIND_ERROR    = 4'd12
   } kind_type;

   typedef enum logic [CODE_BITS-1:0] {
      ERR_NONE           = 3'd0,
      ERR_SLASH_EXPECTED = 3'd1,
      ERR_COMMENT_OPEN   = 3'd2,
      ERR_BAD_ESCAPE     = 3'd3,
      ERR_BAD_STRING_CH  = 3'd4,
      ERR_STRING_OPEN    = 3'd5,
      ERR_SHORT_LITERAL  = 3'd6,
      ERR_UNEXPECTED     = 3'd7
   } err_type;

endpackage

>>> rtl/ast_front.sv
module ast_front
   import ast_pkg::*;
#(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16,
   parameter int OFFSET_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [7:0] in_byte,
   input  logic in_present,
   input  logic in_last,
   input  logic q_full,
   output logic push,
   output logic [CNT_BITS+MAX_RES*(KIND_BITS+CODE_BITS+LINE_BITS+COLUMN_BITS+OFFSET_BITS+LEN_BITS)-1:0]
                push_data
);

   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_UPPER_R = 8'h52;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_LOWER_X = 8'h78;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_COMMENT,
      MODE_STRING,
      MODE_ESCAPE,
      MODE_REGFIRST,
      MODE_REG,
      MODE_IDENT,
      MODE_WORDFIRST,
      MODE_WORD,
      MODE_DONE
   } mode_type;

   typedef enum logic [1:0] {
      BASE_DEC,
      BASE_HEX,
      BASE_BIN
   } base_type;

   typedef struct packed {
      kind_type                kind;
      err_type                 code;
      logic [LINE_BITS-1:0]    line;
      logic [COLUMN_BITS-1:0]  col;
      logic [OFFSET_BITS-1:0]  off;
      logic [LEN_BITS-1:0]     len;
   } res_type;

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dig(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic id_start(input logic [7:0] c);
      return is_alpha(c) || (c == CH_UNDER) || (c == CH_DOLLAR);
   endfunction

   function automatic logic id_inner(input logic [7:0] c);
      return id_start(c) || is_dig(c);
   endfunction

   function automatic logic str_ok(input logic [7:0] c);
      return (c >= 8'h20) && (c <= 8'h7E);
   endfunction

   function automatic logic esc_ok(input logic [7:0] c);
      return (c == CH_DQUOTE) || (c == CH_BSLASH) || (c == 8'h74) || (c == 8'h6E) ||
             (c == 8'h76) || (c == 8'h66) || (c == 8'h72);
   endfunction

   function automatic res_type make_res(input kind_type kind, input err_type code,
                                        input logic [LINE_BITS-1:0] line,
                                        input logic [COLUMN_BITS-1:0] col,
                                        input logic [OFFSET_BITS-1:0] off,
                                        input logic [LEN_BITS-1:0] len);
      res_type r;
      r.kind = kind;
      r.code = code;
      r.line = line;
      r.col  = col;
      r.off  = off;
      r.len  = len;
      return r;
   endfunction

   mode_type                mode_ff, mode_in;
   base_type                base_ff, base_in;
   logic [LINE_BITS-1:0]    line_ff, line_in;
   logic [COLUMN_BITS-1:0]  col_ff, col_in;
   logic [OFFSET_BITS-1:0]  off_ff, off_in;
   logic [COLUMN_BITS-1:0]  tcol_ff, tcol_in;
   logic [OFFSET_BITS-1:0]  toff_ff, toff_in;
   logic [LEN_BITS-1:0]     tlen_ff, tlen_in;
   logic [COLUMN_BITS-1:0]  ecol_ff, ecol_in;
   logic [OFFSET_BITS-1:0]  eoff_ff, eoff_in;
   logic                    pnl_ff, pnl_in;
   logic                    any_ff, any_in;
   logic                    seen_ff, seen_in;

   logic                    accept;
   logic                    again;
   logic                    punct;
   kind_type                pkind;
   logic                    base_digit;
   res_type                 slot [MAX_RES];
   logic [CNT_BITS-1:0]     n_res;

   assign in_ready  = !q_full;
   assign accept    = in_valid && in_ready;
   assign push      = accept && (n_res != '0);
   assign push_data = {n_res, slot[2], slot[1], slot[0]};

   always_comb begin
      unique case (base_ff)
         BASE_HEX: base_digit = is_hex(in_byte);
         BASE_BIN: base_digit = (in_byte == 8'h30) || (in_byte == 8'h31);
         default:  base_digit = is_dig(in_byte);
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      base_in = base_ff;
      line_in = line_ff;
      col_in  = col_ff;
      off_in  = off_ff;
      tcol_in = tcol_ff;
      toff_in = toff_ff;
      tlen_in = tlen_ff;
      ecol_in = ecol_ff;
      eoff_in = eoff_ff;
      pnl_in  = pnl_ff;
      any_in  = any_ff;
      seen_in = seen_ff;
      again   = 1'b0;
      punct   = 1'b0;
      pkind   = KIND_NEWLINE;
      n_res   = '0;
      for (int i = 0; i < MAX_RES; i++) begin
         slot[i] = '0;
      end

      if (accept) begin
         if (in_present) begin
            seen_in = 1'b1;
            // Scan the byte against the token in progress
            unique case (mode_ff)
               MODE_SLASH: begin
                  if (in_byte == CH_SLASH) begin
                     mode_in = MODE_COMMENT;
                  end else begin
                     slot[n_res] = make_res(KIND_ERROR, ERR_SLASH_EXPECTED, line_ff, col_ff,
                                            off_ff, '0);
                     n_res = n_res + 1'b1;
                     mode_in = MODE_DONE;
                  end
               end
               MODE_COMMENT: begin
                  if (in_byte == CH_NL) begin
                     mode_in = MODE_IDLE;
                     again = 1'b1;
                  end
               end
               MODE_STRING: begin
                  if (in_byte == CH_DQUOTE) begin
                     if (tlen_in != '1) tlen_in = tlen_in + 1'b1;
                     slot[n_res] = make_res(KIND_STRING, ERR_NONE, line_ff, tcol_in, toff_in,
                                            tlen_in);
                     n_res = n_res + 1'b1;
                     any_in = 1'b1;
                     pnl_in = 1'b0;
                     mode_in = MODE_IDLE;
                  end else if (in_byte == CH_BSLASH) begin
                     if (tlen_in != '1) tlen_in = tlen_in + 1'b1;
                     ecol_in = col_ff;
                     eoff_in = off_ff;
                     mode_in = MODE_ESCAPE;
                  end else if (str_ok(in_byte)) begin
                     if (tlen_in != '1) tlen_in = tlen_in + 1'b1;
                  end else begin
                     slot[n_res] = make_res(KIND_ERROR, ERR_BAD_STRING_CH, line_ff, col_ff,
                                            off_ff, '0);
                     n_res = n_res + 1'b1;
                     mode_in = MODE_DONE;
                  end
               end
               MODE_ESCAPE: begin
                  if (esc_ok(in_byte)) begin
                     if (tlen_in != '1) tlen_in = tlen_in + 1'b1;
                     mode_in = MODE_STRING;
                  end else begin
                     slot[n_res] = make_res(KIND_ERROR, ERR_BAD_ESCAPE, line_ff, ecol_ff,
                                            eoff_ff, '0);
                     n_res = n_res + 1'b1;
                     mode_in = MODE_DONE;
                  end
               end
               MODE_REGFIRST: begin
                  if (is_dig(in_byte)) begin
                     if (tlen_in != '1) tlen_in = tlen_in + 1'b1;
                     mode_in = MODE_REG;
                  end else if (id_inner(in_byte)) begin
                     if (tlen_in != '1) tlen_in = tlen_in + 1'b1;
                     mode_in = MODE_IDENT;
                  end else begin
                     slot[n_res] = make_res(KIND_IDENT, ERR_NONE, line_ff, tcol_in, toff_in,
                                            tlen_in);
                     n_res = n_res + 1'b1;
                     any_in = 1'b1;
                     pnl_in = 1'b0;
                     mode_in = MODE_IDLE;
                     again = 1'b1;
                  end
               end
               MODE_REG: begin
                  if (is_dig(in_byte)) begin
                     if (tlen_in != '1) tlen_in = tlen_in + 1'b1;
                  end else begin
                     slot[n_res] = make_res(KIND_REGISTER, ERR_NONE, line_ff, tcol_in, toff_in,
                                            tlen_in);
                     n_res = n_res + 1'b1;
                     any_in = 1'b1;
                     pnl_in = 1'b0;
                     mode_in = MODE_IDLE;
                     again = 1'b1;
                  end
               end
               MODE_IDENT: begin
                  if (id_inner(in_byte)) begin
                     if (tlen_in != '1) tlen_in = tlen_in + 1'b1;
                  end else begin
                     slot[n_res] = make_res(KIND_IDENT, ERR_NONE, line_ff, tcol_in, toff_in,
                                            tlen_in);
                     n_res = n_res + 1'b1;
                     any_in = 1'b1;
                     pnl_in = 1'b0;
                     mode_in = MODE_IDLE;
                     again = 1'b1;
                  end
               end
               MODE_WORDFIRST: begin
                  if (in_byte == CH_LOWER_X) begin
                     base_in = BASE_HEX;
                     if (tlen_in != '1) tlen_in = tlen_in + 1'b1;
                     mode_in = MODE_WORD;
                  end else if (in_byte == CH_LOWER_B) begin
                     base_in = BASE_BIN;
                     if (tlen_in != '1) tlen_in = tlen_in + 1'b1;
                     mode_in = MODE_WORD;
                  end else if (is_dig(in_byte)) begin
                     base_in = BASE_DEC;
                     if (tlen_in != '1) tlen_in = tlen_in + 1'b1;
                     mode_in = MODE_WORD;
                  end else begin
                     slot[n_res] = make_res(KIND_WORD, ERR_NONE, line_ff, tcol_in, toff_in,
                                            tlen_in);
                     n_res = n_res + 1'b1;
                     any_in = 1'b1;
                     pnl_in = 1'b0;
                     mode_in = MODE_IDLE;
                     again = 1'b1;
                  end
               end
               MODE_WORD: begin
                  if (base_digit) begin
                     if (tlen_in != '1) tlen_in = tlen_in + 1'b1;
                  end else if ((base_ff != BASE_DEC) && (tlen_in < LEN_BITS'(3))) begin
                     // prefix with no digits after it
                     slot[n_res] = make_res(KIND_ERROR, ERR_SHORT_LITERAL, line_ff, col_ff,
                                            off_ff, '0);
                     n_res = n_res + 1'b1;
                     mode_in = MODE_DONE;
                  end else begin
                     slot[n_res] = make_res(KIND_WORD, ERR_NONE, line_ff, tcol_in, toff_in,
                                            tlen_in);
                     n_res = n_res + 1'b1;
                     any_in = 1'b1;
                     pnl_in = 1'b0;
                     mode_in = MODE_IDLE;
                     again = 1'b1;
                  end
               end
               MODE_IDLE: again = 1'b1;
               default: ;
            endcase

            // Byte that starts something new
            if (again) begin
               tcol_in = col_ff;
               toff_in = off_ff;
               tlen_in = LEN_BITS'(1);
               unique case (in_byte)
                  CH_NL: begin
                     if (!(any_in && pnl_in)) begin
                        slot[n_res] = make_res(KIND_NEWLINE, ERR_NONE, line_ff, col_ff, off_ff,
                                               LEN_BITS'(1));
                        n_res = n_res + 1'b1;
                        any_in = 1'b1;
                        pnl_in = 1'b1;
                     end
                  end
                  CH_STAR: begin
                     punct = 1'b1;
                     pkind = KIND_ASTERISK;
                  end
                  CH_COLON: begin
                     punct = 1'b1;
                     pkind = KIND_COLON;
                  end
                  CH_DOT: begin
                     punct = 1'b1;
                     pkind = KIND_DOT;
                  end
                  CH_COMMA: begin
                     punct = 1'b1;
                     pkind = KIND_COMMA;
                  end
                  CH_LBRACK: begin
                     punct = 1'b1;
                     pkind = KIND_LBRACKET;
                  end
                  CH_RBRACK: begin
                     punct = 1'b1;
                     pkind = KIND_RBRACKET;
                  end
                  CH_SLASH:  mode_in = MODE_SLASH;
                  CH_DQUOTE: mode_in = MODE_STRING;
                  default: begin
                     if (is_space(in_byte)) begin
                        mode_in = mode_in;
                     end else if ((in_byte == CH_LOWER_R) || (in_byte == CH_UPPER_R)) begin
                        mode_in = MODE_REGFIRST;
                     end else if (is_dig(in_byte)) begin
                        mode_in = MODE_WORDFIRST;
                     end else if (id_start(in_byte)) begin
                        mode_in = MODE_IDENT;
                     end else begin
                        slot[n_res] = make_res(KIND_ERROR, ERR_UNEXPECTED, line_ff, col_ff,
                                               off_ff, '0);
                        n_res = n_res + 1'b1;
                        mode_in = MODE_DONE;
                     end
                  end
               endcase
               if (punct) begin
                  slot[n_res] = make_res(pkind, ERR_NONE, line_ff, col_ff, off_ff,
                                         LEN_BITS'(1));
                  n_res = n_res + 1'b1;
                  any_in = 1'b1;
                  pnl_in = 1'b0;
               end
            end

            // Position counters move even after an error
            if (in_byte == CH_NL) begin
               if (line_ff != '1) line_in = line_ff + 1'b1;
               col_in = COLUMN_BITS'(1);
            end else if (col_ff != '1) begin
               col_in = col_ff + 1'b1;
            end
            off_in = off_ff + 1'b1;
         end

         if (in_last) begin
            if ((mode_in != MODE_DONE) && seen_in) begin
               // Close the open token at the end position
               unique case (mode_in)
                  MODE_REGFIRST, MODE_IDENT: begin
                     slot[n_res] = make_res(KIND_IDENT, ERR_NONE, line_in, tcol_in, toff_in,
                                            tlen_in);
                     n_res = n_res + 1'b1;
                     mode_in = MODE_IDLE;
                  end
                  MODE_REG: begin
                     slot[n_res] = make_res(KIND_REGISTER, ERR_NONE, line_in, tcol_in, toff_in,
                                            tlen_in);
                     n_res = n_res + 1'b1;
                     mode_in = MODE_IDLE;
                  end
                  MODE_WORDFIRST: begin
                     slot[n_res] = make_res(KIND_WORD, ERR_NONE, line_in, tcol_in, toff_in,
                                            tlen_in);
                     n_res = n_res + 1'b1;
                     mode_in = MODE_IDLE;
                  end
                  MODE_WORD: begin
                     if ((base_in != BASE_DEC) && (tlen_in < LEN_BITS'(3))) begin
                        slot[n_res] = make_res(KIND_ERROR, ERR_SHORT_LITERAL, line_in, col_in,
                                               off_in, '0);
                        mode_in = MODE_DONE;
                     end else begin
                        slot[n_res] = make_res(KIND_WORD, ERR_NONE, line_in, tcol_in, toff_in,
                                               tlen_in);
                        mode_in = MODE_IDLE;
                     end
                     n_res = n_res + 1'b1;
                  end
                  MODE_SLASH: begin
                     slot[n_res] = make_res(KIND_ERROR, ERR_SLASH_EXPECTED, line_in, col_in,
                                            off_in, '0);
                     n_res = n_res + 1'b1;
                     mode_in = MODE_DONE;
                  end
                  MODE_COMMENT: begin
                     slot[n_res] = make_res(KIND_ERROR, ERR_COMMENT_OPEN, line_in, col_in,
                                            off_in, '0);
                     n_res = n_res + 1'b1;
                     mode_in = MODE_DONE;
                  end
                  MODE_STRING: begin
                     slot[n_res] = make_res(KIND_ERROR, ERR_STRING_OPEN, line_in, col_in,
                                            off_in, '0);
                     n_res = n_res + 1'b1;
                     mode_in = MODE_DONE;
                  end
                  MODE_ESCAPE: begin
                     slot[n_res] = make_res(KIND_ERROR, ERR_BAD_ESCAPE, line_in, ecol_in,
                                            eoff_in, '0);
                     n_res = n_res + 1'b1;
                     mode_in = MODE_DONE;
                  end
                  default: ;
               endcase
               if (mode_in != MODE_DONE) begin
                  slot[n_res] = make_res(KIND_EOF, ERR_NONE, line_in, col_in, off_in, '0);
                  n_res = n_res + 1'b1;
               end
            end
            // Every end marker starts a fresh source
            mode_in = MODE_IDLE;
            base_in = BASE_DEC;
            line_in = LINE_BITS'(1);
            col_in  = COLUMN_BITS'(1);
            off_in  = '0;
            tcol_in = '0;
            toff_in = '0;
            tlen_in = '0;
            ecol_in = '0;
            eoff_in = '0;
            pnl_in  = 1'b0;
            any_in  = 1'b0;
            seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         base_ff <= BASE_DEC;
         line_ff <= LINE_BITS'(1);
         col_ff  <= COLUMN_BITS'(1);
         off_ff  <= '0;
         tcol_ff <= '0;
         toff_ff <= '0;
         tlen_ff <= '0;
         ecol_ff <= '0;
         eoff_ff <= '0;
         pnl_ff  <= 1'b0;
         any_ff  <= 1'b0;
         seen_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         base_ff <= base_in;
         line_ff <= line_in;
         col_ff  <= col_in;
         off_ff  <= off_in;
         tcol_ff <= tcol_in;
         toff_ff <= toff_in;
         tlen_ff <= tlen_in;
         ecol_ff <= ecol_in;
         eoff_ff <= eoff_in;
         pnl_ff  <= pnl_in;
         any_ff  <= any_in;
         seen_ff <= seen_in;
      end
   end

   // After an error the rest of the source makes no results
   assert property (@(posedge clock) disable iff (reset)
      (accept && (mode_ff == MODE_DONE)) |-> !push)
      else $error("result pushed after error");

   // An end marker returns the scanner to its reset position
   assert property (@(posedge clock) disable iff (reset)
      (accept && in_last) |=> ((mode_ff == MODE_IDLE) && (line_ff == LINE_BITS'(1)) &&
                               (off_ff == '0) && !seen_ff))
      else $error("scanner not cleared after end marker");

endmodule

>>> rtl/ast_queue.sv
module ast_queue
   import ast_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0]     mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   assign full       = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      (full || !head_valid) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

>>> rtl/ast_back.sv
module ast_back
   import ast_pkg::*;
#(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16,
   parameter int OFFSET_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   input  logic [CNT_BITS+MAX_RES*(KIND_BITS+CODE_BITS+LINE_BITS+COLUMN_BITS+OFFSET_BITS+LEN_BITS)-1:0]
                head_data,
   output logic pop,
   output logic out_valid,
   input  logic out_ready,
   output kind_type out_kind,
   output err_type  out_code,
   output logic [LINE_BITS-1:0]   out_line,
   output logic [COLUMN_BITS-1:0] out_col,
   output logic [OFFSET_BITS-1:0] out_off,
   output logic [LEN_BITS-1:0]    out_len,
   output logic out_last
);

   localparam int RES_BITS = KIND_BITS + CODE_BITS + LINE_BITS + COLUMN_BITS + OFFSET_BITS + LEN_BITS;
   localparam int BUNDLE_BITS = CNT_BITS + MAX_RES * RES_BITS;

   typedef struct packed {
      kind_type                kind;
      err_type                 code;
      logic [LINE_BITS-1:0]    line;
      logic [COLUMN_BITS-1:0]  col;
      logic [OFFSET_BITS-1:0]  off;
      logic [LEN_BITS-1:0]     len;
   } res_type;

   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic [CNT_BITS-1:0] head_cnt;
   res_type             sel;
   logic                sel_last;
   logic                load;

   kind_type                kind_ff;
   err_type                 code_ff;
   logic [LINE_BITS-1:0]    line_ff;
   logic [COLUMN_BITS-1:0]  col_ff;
   logic [OFFSET_BITS-1:0]  off_ff;
   logic [LEN_BITS-1:0]     len_ff;
   logic                    last_ff;

   assign head_cnt = head_data[BUNDLE_BITS-1 -: CNT_BITS];
   assign sel_last = (idx_ff == (head_cnt - 1'b1));
   assign load     = head_valid && (!valid_ff || out_ready);
   assign pop      = load && sel_last;

   always_comb begin
      unique case (idx_ff)
         2'd0:    sel = res_type'(head_data[0 +: RES_BITS]);
         2'd1:    sel = res_type'(head_data[RES_BITS +: RES_BITS]);
         default: sel = res_type'(head_data[2*RES_BITS +: RES_BITS]);
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = sel_last ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= sel.kind;
         code_ff <= sel.code;
         line_ff <= sel.line;
         col_ff  <= sel.col;
         off_ff  <= sel.off;
         len_ff  <= sel.len;
         last_ff <= sel_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_code  = code_ff;
   assign out_line  = line_ff;
   assign out_col   = col_ff;
   assign out_off   = off_ff;
   assign out_len   = len_ff;
   assign out_last  = last_ff;

   // Slot index always stays inside the head bundle
   assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ((head_cnt != '0) && (idx_ff < head_cnt)))
      else $error("slot index outside bundle");

endmodule

>>> rtl/assembly_source_tokenizer_core.sv
// Assembly source tokenizer.
// req channel: one beat per source byte. req_tdata[7:0] is the byte, req_tuser[0]
// says the byte is present (0 marks a bare end marker), req_tlast ends the source
// after this beat's byte. An idle beat (no byte, no tlast) is accepted and ignored.
// rsp channel: one beat per token or error. rsp_tuser is the token kind;
// rsp_tdata carries error code, line, column, start offset and length;
// rsp_tlast flags the last result that one req beat produced.
// Throughput: one req beat per cycle while the queue has room. A byte yields up
// to three results; the output register drains one result per cycle while
// rsp_tready is high, and a four-entry result queue keeps req flowing meanwhile.
// Order: a beat's results are written into the queue at its accepting edge and
// then loaded one by one into the output register once it is free.
// Stall: while rsp_tready is low the output register holds; once the queue is
// full req_tready drops until a queue entry drains.
// Reset: queue and output empty, scanner idle at line 1, column 1, offset 0.
// After an error, bytes are dropped without results until the end marker.
module assembly_source_tokenizer_core
   import ast_pkg::*;
#(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16,
   parameter int OFFSET_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   // request stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] source_byte
   input  logic [0:0] req_tuser,   // [0] byte_present
   input  logic       req_tlast,   // end_of_source
   // result stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   // error_code, line_number, column_number, start_offset, token_length, zero fill
   output logic [((CODE_BITS+LINE_BITS+COLUMN_BITS+OFFSET_BITS+LEN_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic [KIND_BITS-1:0] rsp_tuser,   // token_kind
   output logic       rsp_tlast    // run_last
);

   localparam int RES_BITS = KIND_BITS + CODE_BITS + LINE_BITS + COLUMN_BITS + OFFSET_BITS + LEN_BITS;
   localparam int BUNDLE_BITS = CNT_BITS + MAX_RES * RES_BITS;
   localparam int RSP_DATA_BITS =
      ((CODE_BITS + LINE_BITS + COLUMN_BITS + OFFSET_BITS + LEN_BITS + 7) / 8) * 8;

   // front -> queue -> back
   logic                    q_push;
   logic [BUNDLE_BITS-1:0]  q_push_data;
   logic                    q_full;
   logic                    q_pop;
   logic                    q_head_valid;
   logic [BUNDLE_BITS-1:0]  q_head_data;

   kind_type                rsp_kind;
   err_type                 rsp_code;
   logic [LINE_BITS-1:0]    rsp_line;
   logic [COLUMN_BITS-1:0]  rsp_col;
   logic [OFFSET_BITS-1:0]  rsp_off;
   logic [LEN_BITS-1:0]     rsp_len;

   // Scanner: classifies each byte and bundles the results it causes
   ast_front #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_present (req_tuser[0]),
      .in_last    (req_tlast),
      .q_full     (q_full),
      .push       (q_push),
      .push_data  (q_push_data)
   );

   // Result bundles waiting for the output side
   ast_queue #(
      .WIDTH (BUNDLE_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   // Unpacks a bundle into one result beat per cycle unless the output is stalled
   ast_back #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .pop        (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_kind   (rsp_kind),
      .out_code   (rsp_code),
      .out_line   (rsp_line),
      .out_col    (rsp_col),
      .out_off    (rsp_off),
      .out_len    (rsp_len),
      .out_last   (rsp_tlast)
   );

   assign rsp_tuser = rsp_kind;
   assign rsp_tdata = RSP_DATA_BITS'({rsp_len, rsp_off, rsp_col, rsp_line, rsp_code});

endmodule

>>> test/assembly_source_tokenizer_core_tb.sv
`timescale 1ns / 1ps

module assembly_source_tokenizer_core_tb;
   import ast_pkg::*;

   // Block configuration (defaults of the core)
   localparam int LINE_W   = 20;
   localparam int COLUMN_W = 16;
   localparam int OFFSET_W = 24;
   localparam int RSP_BITS = ((CODE_BITS + LINE_W + COLUMN_W + OFFSET_W + LEN_BITS + 7) / 8) * 8;

   // rsp_tdata layout, lowest bit up: code, line, column, offset, length
   localparam int LINE_LSB   = CODE_BITS;
   localparam int COLUMN_LSB = LINE_LSB + LINE_W;
   localparam int OFFSET_LSB = COLUMN_LSB + COLUMN_W;
   localparam int LEN_LSB    = OFFSET_LSB + OFFSET_W;

   localparam logic [LINE_W-1:0]   LINE_TOP   = '1;
   localparam logic [COLUMN_W-1:0] COLUMN_TOP = '1;
   localparam logic [LEN_BITS-1:0] LEN_TOP    = '1;

   localparam int WATCHDOG_LIMIT = 2000;   // cycles without any beat
   localparam int DRAIN_CYCLES   = 20;     // covers the result latency
   localparam int PHASE_BEATS    = 55;     // minimum random beats per idling phase

   // Idling phases: none, sender idle, receiver stalling, both
   localparam int NUM_PHASES = 4;
   int unsigned send_idle_pct  [NUM_PHASES] = '{0, 75, 0, 20};
   int unsigned recv_stall_pct [NUM_PHASES] = '{0, 0, 75, 20};

   // Scanner modes of the predictor
   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_SLASH, SCAN_COMMENT, SCAN_STRING, SCAN_ESCAPE, SCAN_REGFIRST,
      SCAN_REG, SCAN_IDENT, SCAN_WORDFIRST, SCAN_WORD, SCAN_DONE
   } scan_type;

   typedef enum logic [1:0] {BASE_DEC, BASE_HEX, BASE_BIN} base_type;

   typedef struct packed {
      kind_type              kind;
      err_type               code;
      logic [LINE_W-1:0]     line;
      logic [COLUMN_W-1:0]   col;
      logic [OFFSET_W-1:0]   off;
      logic [LEN_BITS-1:0]   len;
      logic                  last;
   } token_type;

   // One pending source beat and the idling phase it is sent under
   typedef struct {
      logic [7:0] data;
      bit         present;
      bit         fin;
      int         phase;
      bit         hold;      // wait until all results are in before sending
   } beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;
   logic [0:0]           req_tuser  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]  rsp_tdata;
   logic [KIND_BITS-1:0] rsp_tuser;
   logic                 rsp_tlast;

   beat_type  source_beats[$];      // stimulus not yet sent
   token_type expected_tokens[$];   // predicted results, oldest first
   token_type step_toks[$];         // results of the beat being predicted

   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   int  cur_phase      = 0;      // phase of the last beat driven
   int  gen_phase      = 0;      // phase given to beats being queued
   bit  next_hold      = 1'b0;
   bit  drained        = 1'b1;   // registered: nothing expected after last edge

   // Predictor state
   scan_type              sc_mode;
   base_type              sc_base;
   logic [LINE_W-1:0]     sc_line;
   logic [COLUMN_W-1:0]   sc_col, tk_col, esc_col;
   logic [OFFSET_W-1:0]   sc_off, tk_off, esc_off;
   logic [LEN_BITS-1:0]   tk_len;
   bit                    last_nl, any_tok, bytes_seen;

   always #1 clock = ~clock;

   assembly_source_tokenizer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ---------------------------------------------------------------------
   // Character classes
   // ---------------------------------------------------------------------
   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_hex(logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic bit is_space(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit is_id_start(logic [7:0] c);
      return is_alpha(c) || c == "_" || c == "$";
   endfunction

   function automatic bit is_id_inner(logic [7:0] c);
      return is_id_start(c) || is_digit(c);
   endfunction

   function automatic bit is_escape(logic [7:0] c);
      return c == "\"" || c == "\\" || c == "t" || c == "n" || c == "v" || c == "f" || c == "r";
   endfunction

   // ---------------------------------------------------------------------
   // Tokenizer predictor
   // ---------------------------------------------------------------------
   function automatic void reset_scanner();
      sc_mode    = SCAN_IDLE;
      sc_base    = BASE_DEC;
      sc_line    = LINE_W'(1);
      sc_col     = COLUMN_W'(1);
      sc_off     = '0;
      tk_col     = '0;
      tk_off     = '0;
      tk_len     = '0;
      last_nl    = 1'b0;
      any_tok    = 1'b0;
      bytes_seen = 1'b0;
      esc_col    = '0;
      esc_off    = '0;
   endfunction

   // At most MAX_RES results per beat
   function automatic void queue_result(kind_type k, err_type c, logic [COLUMN_W-1:0] col,
                                        logic [OFFSET_W-1:0] off, logic [LEN_BITS-1:0] len);
      token_type t;
      if (step_toks.size() < MAX_RES) begin
         t.kind = k;
         t.code = c;
         t.line = sc_line;
         t.col  = col;
         t.off  = off;
         t.len  = len;
         t.last = 1'b0;
         step_toks.push_back(t);
      end
   endfunction

   function automatic void put_token(kind_type k, logic [COLUMN_W-1:0] col,
                                     logic [OFFSET_W-1:0] off, logic [LEN_BITS-1:0] len);
      queue_result(k, ERR_NONE, col, off, len);
      any_tok = 1'b1;
      last_nl = (k == KIND_NEWLINE);
   endfunction

   function automatic void raise_error(err_type c, logic [COLUMN_W-1:0] col,
                                       logic [OFFSET_W-1:0] off);
      queue_result(KIND_ERROR, c, col, off, '0);
      sc_mode = SCAN_DONE;
   endfunction

   function automatic void grow();
      if (tk_len != LEN_TOP) tk_len++;
   endfunction

   function automatic void close_pending(kind_type k);
      put_token(k, tk_col, tk_off, tk_len);
      sc_mode = SCAN_IDLE;
   endfunction

   // Close whatever token is open, error position col/off
   function automatic void close_open(logic [COLUMN_W-1:0] col, logic [OFFSET_W-1:0] off);
      case (sc_mode)
         SCAN_REGFIRST, SCAN_IDENT: close_pending(KIND_IDENT);
         SCAN_REG:       close_pending(KIND_REGISTER);
         SCAN_WORDFIRST: close_pending(KIND_WORD);
         SCAN_WORD: begin
            // prefixed literal needs at least one digit after 0x / 0b
            if (sc_base != BASE_DEC && tk_len < LEN_BITS'(3))
               raise_error(ERR_SHORT_LITERAL, col, off);
            else close_pending(KIND_WORD);
         end
         SCAN_SLASH:   raise_error(ERR_SLASH_EXPECTED, col, off);
         SCAN_COMMENT: raise_error(ERR_COMMENT_OPEN, col, off);
         SCAN_STRING:  raise_error(ERR_STRING_OPEN, col, off);
         SCAN_ESCAPE:  raise_error(ERR_BAD_ESCAPE, esc_col, esc_off);
         default: ;
      endcase
   endfunction

   // Byte seen between tokens
   function automatic void start_token(logic [7:0] b, logic [COLUMN_W-1:0] col,
                                       logic [OFFSET_W-1:0] off);
      kind_type k;
      bit       is_mark;
      k       = KIND_ERROR;
      is_mark = 1'b1;
      tk_col  = col;
      tk_off  = off;
      tk_len  = LEN_BITS'(1);
      case (b)
         "*":     k = KIND_ASTERISK;
         ":":     k = KIND_COLON;
         ".":     k = KIND_DOT;
         ",":     k = KIND_COMMA;
         "[":     k = KIND_LBRACKET;
         "]":     k = KIND_RBRACKET;
         default: is_mark = 1'b0;
      endcase
      if (b == 8'h0A) begin
         // repeated newlines collapse into one token
         if (!(any_tok && last_nl)) put_token(KIND_NEWLINE, col, off, LEN_BITS'(1));
      end else if (b == "/") begin
         sc_mode = SCAN_SLASH;
      end else if (b == "\"") begin
         sc_mode = SCAN_STRING;
      end else if (is_mark) begin
         put_token(k, col, off, LEN_BITS'(1));
      end else if (is_space(b)) begin
         // whitespace only separates
      end else if (b == "r" || b == "R") begin
         sc_mode = SCAN_REGFIRST;
      end else if (is_digit(b)) begin
         sc_mode = SCAN_WORDFIRST;
      end else if (is_id_start(b)) begin
         sc_mode = SCAN_IDENT;
      end else begin
         raise_error(ERR_UNEXPECTED, col, off);
      end
   endfunction

   function automatic void scan_byte(logic [7:0] b);
      logic [COLUMN_W-1:0] col;
      logic [OFFSET_W-1:0] off;
      bit                  again;
      col   = sc_col;
      off   = sc_off;
      again = 1'b0;
      case (sc_mode)
         SCAN_SLASH: begin
            if (b == "/") sc_mode = SCAN_COMMENT;
            else raise_error(ERR_SLASH_EXPECTED, col, off);
         end
         SCAN_COMMENT: begin
            if (b == 8'h0A) begin
               sc_mode = SCAN_IDLE;
               again   = 1'b1;
            end
         end
         SCAN_STRING: begin
            if (b == "\"") begin
               grow();
               close_pending(KIND_STRING);
            end else if (b == "\\") begin
               grow();
               esc_col = col;
               esc_off = off;
               sc_mode = SCAN_ESCAPE;
            end else if (b >= 8'h20 && b <= 8'h7E) begin
               grow();
            end else begin
               raise_error(ERR_BAD_STRING_CH, col, off);
            end
         end
         SCAN_ESCAPE: begin
            // bad escape is reported at the backslash
            if (is_escape(b)) begin
               grow();
               sc_mode = SCAN_STRING;
            end else begin
               raise_error(ERR_BAD_ESCAPE, esc_col, esc_off);
            end
         end
         SCAN_REGFIRST: begin
            if (is_digit(b)) begin
               grow();
               sc_mode = SCAN_REG;
            end else if (is_id_inner(b)) begin
               grow();
               sc_mode = SCAN_IDENT;
            end else begin
               close_pending(KIND_IDENT);
               again = 1'b1;
            end
         end
         SCAN_REG: begin
            if (is_digit(b)) grow();
            else begin
               close_pending(KIND_REGISTER);
               again = 1'b1;
            end
         end
         SCAN_IDENT: begin
            if (is_id_inner(b)) grow();
            else begin
               close_pending(KIND_IDENT);
               again = 1'b1;
            end
         end
         SCAN_WORDFIRST: begin
            if (b == "x" || b == "b" || is_digit(b)) begin
               sc_base = (b == "x") ? BASE_HEX : (b == "b") ? BASE_BIN : BASE_DEC;
               grow();
               sc_mode = SCAN_WORD;
            end else begin
               // lone digit is a one-byte word
               close_pending(KIND_WORD);
               again = 1'b1;
            end
         end
         SCAN_WORD: begin
            if ((sc_base == BASE_HEX && is_hex(b)) ||
                (sc_base == BASE_BIN && (b == "0" || b == "1")) ||
                (sc_base == BASE_DEC && is_digit(b))) begin
               grow();
            end else begin
               close_open(col, off);
               again = (sc_mode != SCAN_DONE);
            end
         end
         SCAN_IDLE: again = 1'b1;
         default: ;   // after an error bytes are dropped
      endcase
      if (again) start_token(b, col, off);
   endfunction

   // Work out the results of one accepted request beat
   function automatic void tokenize_beat(logic [7:0] b, bit present, bit fin);
      token_type t;
      step_toks.delete();
      if (present) begin
         bytes_seen = 1'b1;
         if (sc_mode != SCAN_DONE) scan_byte(b);
         if (b == 8'h0A) begin
            if (sc_line != LINE_TOP) sc_line++;
            sc_col = COLUMN_W'(1);
         end else if (sc_col != COLUMN_TOP) begin
            sc_col++;
         end
         sc_off++;
      end
      if (fin) begin
         // empty source and sources ended by an error give nothing here
         if (sc_mode != SCAN_DONE && bytes_seen) begin
            if (sc_mode != SCAN_IDLE) close_open(sc_col, sc_off);
            if (sc_mode != SCAN_DONE) put_token(KIND_EOF, sc_col, sc_off, '0);
         end
         reset_scanner();
      end
      foreach (step_toks[i]) begin
         t      = step_toks[i];
         t.last = (i == step_toks.size() - 1);
         expected_tokens.push_back(t);
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------
   function automatic void add_beat(logic [7:0] data, bit present, bit fin);
      beat_type b;
      b.data    = data;
      b.present = present;
      b.fin     = fin;
      b.phase   = gen_phase;
      b.hold    = next_hold;
      next_hold = 1'b0;
      source_beats.push_back(b);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_beat(s[i], 1'b1, 1'b0);
   endfunction

   function automatic logic [7:0] pick_char(string s);
      return s[$urandom_range(s.len() - 1)];
   endfunction

   function automatic logic [7:0] printable();
      logic [7:0] c;
      c = 8'($urandom_range(32, 126));
      if (c == "\"" || c == "\\") c = "a";
      return c;
   endfunction

   function automatic void add_separator();
      case ($urandom_range(3))
         0:       add_beat(" ", 1'b1, 1'b0);
         1:       add_beat(8'h0A, 1'b1, 1'b0);
         2:       add_beat(8'h09, 1'b1, 1'b0);
         default: add_beat(pick_char("*:.,[]"), 1'b1, 1'b0);
      endcase
   endfunction

   // One token-sized piece of source; rough adds broken and noisy pieces
   function automatic void add_fragment(bit rough);
      string      id_chars;
      logic [7:0] c;
      int         n;
      id_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_$0123456789";
      case (rough ? $urandom_range(14) : $urandom_range(10))
         0: add_beat(pick_char("*:.,[]"), 1'b1, 1'b0);
         1: repeat ($urandom_range(1, 3)) add_beat(8'h0A, 1'b1, 1'b0);
         2: repeat ($urandom_range(1, 3)) begin
            c = $urandom_range(1) ? 8'(" ") : 8'($urandom_range(9, 13));
            add_beat(c, 1'b1, 1'b0);
         end
         3: begin
            add_beat($urandom_range(1) ? "r" : "R", 1'b1, 1'b0);
            repeat ($urandom_range(3)) add_beat(pick_char("0123456789"), 1'b1, 1'b0);
         end
         4: begin
            add_beat(id_chars[$urandom_range(53)], 1'b1, 1'b0);
            repeat ($urandom_range(5)) add_beat(id_chars[$urandom_range(63)], 1'b1, 1'b0);
         end
         5: repeat ($urandom_range(1, 4)) add_beat(pick_char("0123456789"), 1'b1, 1'b0);
         6, 7: begin
            add_beat(pick_char("0123456789"), 1'b1, 1'b0);
            n = rough ? $urandom_range(4) : $urandom_range(1, 4);
            if ($urandom_range(1)) begin
               add_beat("x", 1'b1, 1'b0);
               repeat (n) add_beat(pick_char("0123456789abcdefABCDEF"), 1'b1, 1'b0);
            end else begin
               add_beat("b", 1'b1, 1'b0);
               repeat (n) add_beat(pick_char("01"), 1'b1, 1'b0);
            end
         end
         8: begin
            add_beat("\"", 1'b1, 1'b0);
            repeat ($urandom_range(6)) begin
               if ($urandom_range(4) == 0) begin
                  add_beat("\\", 1'b1, 1'b0);
                  add_beat(pick_char("\"\\tnvfr"), 1'b1, 1'b0);
               end else begin
                  add_beat(printable(), 1'b1, 1'b0);
               end
            end
            add_beat("\"", 1'b1, 1'b0);
         end
         9: begin
            add_text("//");
            repeat ($urandom_range(8)) begin
               c = 8'($urandom_range(255));
               add_beat((c == 8'h0A) ? 8'(" ") : c, 1'b1, 1'b0);
            end
            add_beat(8'h0A, 1'b1, 1'b0);
         end
         10: add_beat(8'($urandom_range(255)), 1'b0, 1'b0);   // idle beat
         11: add_beat(8'($urandom_range(255)), 1'b1, 1'b0);   // noise
         12: begin
            c = 8'($urandom_range(255));
            add_beat("/", 1'b1, 1'b0);
            add_beat((c == "/") ? 8'("x") : c, 1'b1, 1'b0);
         end
         13: begin
            c = $urandom_range(1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(127, 255));
            add_beat("\"", 1'b1, 1'b0);
            repeat ($urandom_range(2)) add_beat(printable(), 1'b1, 1'b0);
            add_beat(c, 1'b1, 1'b0);
         end
         default: begin
            c = 8'($urandom_range(255));
            add_beat("\"", 1'b1, 1'b0);
            add_beat("\\", 1'b1, 1'b0);
            add_beat(is_escape(c) ? 8'("q") : c, 1'b1, 1'b0);
         end
      endcase
   endfunction

   // Source left open right before its end marker
   function automatic void add_open_tail();
      case ($urandom_range(5))
         0: add_beat("/", 1'b1, 1'b0);
         1: begin
            add_text("//");
            repeat ($urandom_range(3)) add_beat(printable(), 1'b1, 1'b0);
         end
         2: begin
            add_beat("\"", 1'b1, 1'b0);
            repeat ($urandom_range(3)) add_beat(printable(), 1'b1, 1'b0);
         end
         3: add_text("\"a\\");
         4: add_text("0x");
         default: add_text("1b");
      endcase
   endfunction

   function automatic void add_source(bit rough);
      beat_type last_beat;
      if ($urandom_range(9) == 0) next_hold = 1'b1;
      if (rough && $urandom_range(4) == 0) begin
         add_beat(8'($urandom_range(255)), 1'b0, 1'b1);   // empty source
         return;
      end
      repeat ($urandom_range(1, 8)) begin
         add_fragment(rough && $urandom_range(3) == 0);
         if ($urandom_range(99) < 60) add_separator();
      end
      if (rough && $urandom_range(1)) add_open_tail();
      // end either on the last byte or by a bare end marker
      if ($urandom_range(1)) begin
         last_beat     = source_beats.pop_back();
         last_beat.fin = 1'b1;
         source_beats.push_back(last_beat);
      end else begin
         add_beat(8'($urandom_range(255)), 1'b0, 1'b1);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: request beats from the queue, random receiver stalls
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : beat_driver
      beat_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct[cur_phase]);
         if (!req_tvalid || req_tready) begin
            // a hold beat waits for an empty request side and all results in
            if (source_beats.size() != 0 &&
                (!source_beats[0].hold || (!req_tvalid && drained)) &&
                $urandom_range(99) >= send_idle_pct[source_beats[0].phase]) begin
               beat = source_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= beat.data;
               req_tuser  <= beat.present;
               req_tlast  <= beat.fin;
               cur_phase  <= beat.phase;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on request beats, check result beats
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : token_monitor
      token_type want;
      if (reset) begin
         drained <= 1'b1;
      end else begin
         if (req_tvalid && req_tready) tokenize_beat(req_tdata, req_tuser[0], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               $error("unexpected result beat: kind %0d", rsp_tuser);
               mismatch_count++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("token_kind", want.kind, rsp_tuser);
               check_field("error_code", want.code, rsp_tdata[CODE_BITS-1:0]);
               check_field("line_number", want.line, rsp_tdata[LINE_LSB +: LINE_W]);
               check_field("column_number", want.col, rsp_tdata[COLUMN_LSB +: COLUMN_W]);
               check_field("start_offset", want.off, rsp_tdata[OFFSET_LSB +: OFFSET_W]);
               check_field("token_length", want.len, rsp_tdata[LEN_LSB +: LEN_BITS]);
               check_field("run_last", want.last, rsp_tlast);
            end
         end
         drained <= (expected_tokens.size() == 0);
      end
   end

   // Watchdog: no beat on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      int goal;
      reset_scanner();

      // punctuation, collapsed newline, idle beat, high-bit byte is unexpected
      add_text("*:.,[]\n\n");
      add_beat(8'h5A, 1'b0, 1'b0);
      add_beat(8'hFF, 1'b1, 1'b1);
      // empty source: bare end marker gives nothing
      add_beat(8'h00, 1'b0, 1'b1);
      // backslash right before the end
      add_beat("\"", 1'b1, 1'b0);
      add_beat("\\", 1'b1, 1'b1);
      // hex prefix with no digit at the end
      add_beat("0", 1'b1, 1'b0);
      add_beat("x", 1'b1, 1'b1);
      // register closed by a bare end marker, then a zero byte
      add_text("R7");
      add_beat(8'hA5, 1'b0, 1'b1);
      add_beat(8'h00, 1'b1, 1'b1);
      // identifier, then one closed by the end marker on its own byte
      add_text("abc ");
      add_beat("b", 1'b1, 1'b1);

      // random sources, one idling phase after another
      for (int p = 0; p < NUM_PHASES; p++) begin
         gen_phase = p;
         next_hold = 1'b1;
         goal = source_beats.size() + PHASE_BEATS;
         while (source_beats.size() < goal) add_source($urandom_range(3) == 0);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (source_beats.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_tokens.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
